// ----- hdl/pio_pkg.sv -----
// Shared types and constants of the pulse interval odometer.
// No dependencies; used by the controller, the datapath and the top level.
package pio_pkg;

  localparam int BatchLen = 16;
  localparam int AddrW    = $clog2(BatchLen);
  localparam int CntW     = $clog2(BatchLen + 1);
  localparam int BcntW    = 5;

  localparam logic [1:0] OP_EDGE = 2'd0;
  localparam logic [1:0] OP_OVF  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] REG_METRES    = 3'd0;
  localparam logic [2:0] REG_RECOVERED = 3'd1;
  localparam logic [2:0] REG_STEP_THR  = 3'd2;
  localparam logic [2:0] REG_SPREAD    = 3'd3;
  localparam logic [2:0] REG_TEST      = 3'd4;

  localparam logic [31:0] MetresReset = 32'd65536;
  localparam logic [15:0] StepThrReset = 16'd1500;
  localparam logic [15:0] SpreadReset  = 16'd500;

  typedef struct packed {
    logic accept;
    logic scan_clr;
    logic scan_step;
    logic scan_count;
    logic eval;
    logic pulse;
    logic mul;
    logic mile;
    logic out_load;
  } pio_cmd_t;

  typedef struct packed {
    logic formed;
    logic batch;
    logic mile;
    logic scan_done;
    logic all_count;
  } pio_status_t;

endpackage

// ----- hdl/pulse_interval_odometer.sv -----
// Wheel-pulse interval meter and trip odometer. Each transfer on the input
// stream is one event (edge capture, timer overflow or rate window tick) and
// yields exactly one result transfer. A timer event or an edge that closes no
// batch goes from accept straight to the result, through the multiply and
// mileage steps when the trip mileage is recomputed; the edge that fills the
// sixteen-entry interval store makes two sequential passes over the single
// read port of the store (one for max/min, one for the qualifying count) and
// skips the second pass when the whole batch counts.
// The output register lets the next event enter while a result waits.
// Depends on pio_pkg, pio_ctrl, pio_dp and pio_ram.
module pulse_interval_odometer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,  // capture_time[15:0], trip_active[16], zero
  input  logic [1:0]   s_axis_tuser,  // opcode[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // interval[15:0], interval_valid[16], batch_done[17], batch_count[22:18],
  // trip_pulses[54:23], trip_mileage[86:55], step_rate[102:87], rate_valid[103]
  output logic [103:0] m_axis_tdata
);
  import pio_pkg::*;

  pio_cmd_t    cmd;
  pio_status_t st;

  logic [15:0]      interval, step_rate;
  logic             interval_valid, batch_done, rate_valid;
  logic [BcntW-1:0] batch_count;
  logic [31:0]      trip_pulses, trip_mileage;

  pio_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  pio_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (s_axis_tuser),
    .capture_time_i   (s_axis_tdata[15:0]),
    .trip_active_i    (s_axis_tdata[16]),
    .cmd_i            (cmd),
    .st_o             (st),
    .interval_o       (interval),
    .interval_valid_o (interval_valid),
    .batch_done_o     (batch_done),
    .batch_count_o    (batch_count),
    .trip_pulses_o    (trip_pulses),
    .trip_mileage_o   (trip_mileage),
    .step_rate_o      (step_rate),
    .rate_valid_o     (rate_valid)
  );

  assign m_axis_tdata = {rate_valid, step_rate, trip_mileage, trip_pulses,
                         batch_count, batch_done, interval_valid, interval};

  // an accepted event closes the input in the cycle after the transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted again in the cycle after a transfer");

  // a batch is only judged by an edge that formed an interval
  a_batch_needs_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[17] || m_axis_tdata[16]))
    else $error("batch_done without interval_valid");

  // a window tick never carries an interval
  a_rate_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[103] && m_axis_tdata[16]))
    else $error("rate_valid and interval_valid together");

endmodule

// ----- hdl/pio_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pio_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pio_ctrl.sv -----
// Sequencer of the pulse interval odometer: steps the datapath through
// accept, the two store scans, pulse and mileage update and result hand-off.
// Depends on pio_pkg.
module pio_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  input  pio_pkg::pio_status_t st_i,
  output pio_pkg::pio_cmd_t    cmd_o
);
  import pio_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_MM, S_EVAL, S_SCAN_CNT, S_PULSE, S_MUL, S_MILE, S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   mile_q, mile_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    mile_d      = mile_q;
    out_valid_d = out_valid_q & ~m_ready_i;
    case (state_q)
      S_IDLE: begin
        cmd_o.scan_clr = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          mile_d       = st_i.mile;
          if (st_i.batch) begin
            state_d = S_SCAN_MM;
          end else if (st_i.mile) begin
            state_d = S_MUL;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_SCAN_MM: begin
        cmd_o.scan_step = 1'b1;
        if (st_i.scan_done) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval     = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d        = st_i.all_count ? S_PULSE : S_SCAN_CNT;
      end
      S_SCAN_CNT: begin
        cmd_o.scan_step  = 1'b1;
        cmd_o.scan_count = 1'b1;
        if (st_i.scan_done) begin
          state_d = S_PULSE;
        end
      end
      S_PULSE: begin
        cmd_o.pulse = 1'b1;
        state_d     = mile_q ? S_MUL : S_RESULT;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_MILE;
      end
      S_MILE: begin
        cmd_o.mile = 1'b1;
        state_d    = S_RESULT;
      end
      S_RESULT: begin
        // hold the result until the output register is free
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mile_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mile_q      <= mile_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;

endmodule

// ----- hdl/pio_dp.sv -----
// Datapath of the pulse interval odometer: configuration registers, edge
// stamps, interval store, batch judging, pulse total, mileage and result
// register. Depends on pio_pkg and pio_ram.
module pio_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [1:0]           opcode_i,
  input  logic [15:0]          capture_time_i,
  input  logic                 trip_active_i,
  input  pio_pkg::pio_cmd_t    cmd_i,
  output pio_pkg::pio_status_t st_o,
  output logic [15:0]          interval_o,
  output logic                 interval_valid_o,
  output logic                 batch_done_o,
  output logic [pio_pkg::BcntW-1:0] batch_count_o,
  output logic [31:0]          trip_pulses_o,
  output logic [31:0]          trip_mileage_o,
  output logic [15:0]          step_rate_o,
  output logic                 rate_valid_o
);
  import pio_pkg::*;

  // configuration
  logic [31:0] metres_q, recovered_q;
  logic [15:0] step_thr_q, spread_q;
  logic        test_q;

  // event state
  logic            phase_q;
  logic [15:0]     rise_q, fall_q, ovf_q, steps_q;
  logic [CntW-1:0] fill_q;
  logic [31:0]     pulse_q, mileage_q;
  logic [63:0]     prod_q;

  // scan state
  logic [CntW-1:0] scan_idx_q, hits_q;
  logic            rd_valid_q, first_q;
  logic [15:0]     hi_q, lo_q;
  logic [15:0]     rd_data;

  // per-item result fields
  logic [15:0]     ival_q, rate_q;
  logic            ival_ok_q, done_q, rate_ok_q;
  logic [CntW-1:0] bcnt_q;

  // output register
  logic [15:0]      o_ival_q, o_rate_q;
  logic             o_ival_ok_q, o_done_q, o_rate_ok_q;
  logic [BcntW-1:0] o_bcnt_q;
  logic [31:0]      o_pulses_q, o_mileage_q;

  logic [15:0]     other, ival_c;
  logic            is_edge, formed;
  logic [CntW-1:0] fill_inc;
  logic [16:0]     lo_plus_spread;

  always_comb begin
    other    = phase_q ? fall_q : rise_q;
    // overflow weight 65535 is minus one modulo 2^16
    ival_c   = capture_time_i - other - ovf_q;
    is_edge  = (opcode_i == OP_EDGE);
    formed   = is_edge && (other != 16'd0);
    fill_inc = fill_q + CntW'(1);
    lo_plus_spread = {1'b0, lo_q} + {1'b0, spread_q};
    st_o.formed    = formed;
    st_o.batch     = formed && (fill_inc == CntW'(BatchLen));
    st_o.mile      = formed && !test_q && trip_active_i;
    st_o.scan_done = (scan_idx_q == CntW'(BatchLen));
    st_o.all_count = ({1'b0, hi_q} < lo_plus_spread);
  end

  pio_ram #(
    .Width (16),
    .Depth (BatchLen)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && formed),
    .waddr_i (fill_q[AddrW-1:0]),
    .wdata_i (ival_c),
    .raddr_i (scan_idx_q[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metres_q    <= MetresReset;
      recovered_q <= '0;
      step_thr_q  <= StepThrReset;
      spread_q    <= SpreadReset;
      test_q      <= 1'b0;
      phase_q     <= 1'b1;
      rise_q      <= '0;
      fall_q      <= '0;
      ovf_q       <= '0;
      steps_q     <= '0;
      fill_q      <= '0;
      pulse_q     <= '0;
      mileage_q   <= '0;
      scan_idx_q  <= '0;
      rd_valid_q  <= 1'b0;
      first_q     <= 1'b1;
      hits_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_METRES:    metres_q    <= cfg_data_i;
          REG_RECOVERED: recovered_q <= cfg_data_i;
          REG_STEP_THR:  step_thr_q  <= cfg_data_i[15:0];
          REG_SPREAD:    spread_q    <= cfg_data_i[15:0];
          REG_TEST:      test_q      <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (cmd_i.accept) begin
        case (opcode_i)
          OP_EDGE: begin
            if (phase_q) begin
              rise_q <= capture_time_i;
            end else begin
              fall_q <= capture_time_i;
            end
            phase_q <= ~phase_q;
            if (formed) begin
              ovf_q  <= '0;
              fill_q <= fill_inc;
              if (ival_c > step_thr_q) begin
                steps_q <= steps_q + 16'd1;
              end
            end
          end
          OP_OVF:  ovf_q   <= ovf_q + 16'd1;
          OP_TICK: steps_q <= '0;
          default: ;
        endcase
      end

      if (cmd_i.scan_clr) begin
        scan_idx_q <= '0;
        rd_valid_q <= 1'b0;
        first_q    <= 1'b1;
      end else if (cmd_i.scan_step) begin
        if (scan_idx_q != CntW'(BatchLen)) begin
          scan_idx_q <= scan_idx_q + CntW'(1);
          rd_valid_q <= 1'b1;
        end else begin
          rd_valid_q <= 1'b0;
        end
        if (rd_valid_q) begin
          first_q <= 1'b0;
        end
      end

      if (cmd_i.eval) begin
        hits_q <= st_o.all_count ? CntW'(BatchLen) : '0;
      end else if (cmd_i.scan_step && cmd_i.scan_count && rd_valid_q &&
                   (rd_data > {2'b00, hi_q[15:2]})) begin
        hits_q <= hits_q + CntW'(1);
      end

      if (cmd_i.pulse) begin
        pulse_q <= pulse_q + 32'(hits_q >> 1);
        fill_q  <= '0;
      end

      if (cmd_i.mile) begin
        mileage_q <= recovered_q + prod_q[47:16];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && !cmd_i.scan_count && rd_valid_q) begin
      if (first_q || rd_data > hi_q) begin
        hi_q <= rd_data;
      end
      if (first_q || rd_data < lo_q) begin
        lo_q <= rd_data;
      end
    end

    if (cmd_i.mul) begin
      prod_q <= {32'd0, pulse_q} * {32'd0, metres_q};
    end

    if (cmd_i.accept) begin
      ival_q    <= formed ? ival_c : 16'd0;
      ival_ok_q <= formed;
      done_q    <= 1'b0;
      bcnt_q    <= '0;
      rate_q    <= (opcode_i == OP_TICK) ? steps_q : 16'd0;
      rate_ok_q <= (opcode_i == OP_TICK);
    end else if (cmd_i.pulse) begin
      done_q <= 1'b1;
      bcnt_q <= hits_q;
    end

    if (cmd_i.out_load) begin
      o_ival_q    <= ival_q;
      o_ival_ok_q <= ival_ok_q;
      o_done_q    <= done_q;
      o_bcnt_q    <= BcntW'(bcnt_q);
      o_pulses_q  <= pulse_q;
      o_mileage_q <= mileage_q;
      o_rate_q    <= rate_q;
      o_rate_ok_q <= rate_ok_q;
    end
  end

  assign interval_o       = o_ival_q;
  assign interval_valid_o = o_ival_ok_q;
  assign batch_done_o     = o_done_q;
  assign batch_count_o    = o_bcnt_q;
  assign trip_pulses_o    = o_pulses_q;
  assign trip_mileage_o   = o_mileage_q;
  assign step_rate_o      = o_rate_q;
  assign rate_valid_o     = o_rate_ok_q;

endmodule
